FILE: design/rdcd_pkg.sv
// Shared types, codes and constants for the rolling decimal counter display.
// No dependencies; every other design file imports this package.

package rdcd_pkg;

    // Fixed field widths of the channels.
    localparam int FUNC_W     = 3;
    localparam int VALUE_W    = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int THRESH_W   = 16;
    localparam int PERIOD_W   = 4;
    localparam int BCD_W      = 32;
    localparam int VIS_W      = 8;

    // Digit count defaults and the most digits the result fields can carry.
    localparam int DIGITS_DEFAULT = 8;
    localparam int MAX_SHOWN      = 8;

    // Depth of the queue between the front and the back end.
    localparam int QUEUE_DEPTH = 4;

    // Reciprocal of ten: (v * RECIP_10) >> 35 equals v / 10 for every 32-bit v,
    // and a shift by 36 gives v / 20.
    localparam logic [31:0] RECIP_10  = 32'hCCCC_CCCD;
    localparam int          SHIFT_DIV10 = 35;
    localparam int          SHIFT_DIV20 = 36;

    // Function codes of an incoming transaction.
    localparam logic [FUNC_W-1:0] FUNC_TICK   = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_ADD    = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_SET    = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_FINISH = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 3'd4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SNAP_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SOUND_PERIOD   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ANIM_OFF       = 2'd2;

    // Configuration reset values.
    localparam logic [THRESH_W-1:0] SNAP_THRESHOLD_RST = 16'd30;
    localparam logic [PERIOD_W-1:0] SOUND_PERIOD_RST   = 4'd10;

    // Operation after classification by the front end.
    typedef enum logic [2:0] {
        OP_TICK,
        OP_ADD,
        OP_SET,
        OP_FINISH,
        OP_CLEAR,
        OP_NOP
    } op_t;

    // Current configuration.
    typedef struct packed {
        logic [THRESH_W-1:0] snap_threshold;
        logic [PERIOD_W-1:0] sound_period;
        logic                anim_off;
    } cfg_t;

    // One queued operation.
    typedef struct packed {
        op_t                op;
        logic [VALUE_W-1:0] amount;
    } q_entry_t;

    // Outcome of one operation before the digits are added.
    typedef struct packed {
        logic               updated;
        logic               sound;
        logic               animating;
        logic [VALUE_W-1:0] value;
    } result_t;

    // One stage of the digit pipeline.
    typedef struct packed {
        result_t            res;
        logic [VALUE_W-1:0] rest;
        logic [BCD_W-1:0]   bcd;
        logic [VIS_W-1:0]   vis;
    } dstage_t;

endpackage

FILE: design/rdcd_ifs.sv
// Channel interfaces of the rolling decimal counter display: commands,
// results and configuration writes. Depends on rdcd_pkg.

interface rdcd_cmd_if
    import rdcd_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [FUNC_W-1:0]  func;
    logic [VALUE_W-1:0] amount;

    modport source (output valid, func, amount, input ready);
    modport sink   (input valid, func, amount, output ready);
endinterface

interface rdcd_rsp_if
    import rdcd_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               display_updated;
    logic               play_sound;
    logic               animating;
    logic [VALUE_W-1:0] shown_value;
    logic [BCD_W-1:0]   digits_bcd;
    logic [VIS_W-1:0]   digit_visible;

    modport source (output valid, display_updated, play_sound, animating, shown_value,
                    digits_bcd, digit_visible, input ready);
    modport sink   (input valid, display_updated, play_sound, animating, shown_value,
                    digits_bcd, digit_visible, output ready);
endinterface

interface rdcd_cfg_if
    import rdcd_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: design/rolling_decimal_counter_display_top.sv
// Top level of the rolling decimal counter display: front end, queue, back
// end and digit pipeline. Depends on rdcd_pkg and rdcd_ifs.
//
// Usage:
// - cmd carries one transaction per operation: func (tick, add, set, finish,
//   clear) and a 32-bit amount. Every command transaction yields exactly one
//   rsp transaction, in order.
// - cfg writes snap_threshold (index 0), sound_period (1) and anim_off (2);
//   it is always ready and should be written while no command is in flight.
// - rsp carries the refresh flag, sound pulse, animating flag, shown value,
//   packed decimal digits and the digit visibility mask.
// A result passes through the queue, the back end and the digit stages
// (capped at 8 digit stages) before rsp offers it; a tick also passes the
// back end's apply state.
// Throughput: one non-tick command per cycle while rsp takes results; a tick
// holds the back end in an evaluate state, which forms the distance, and then
// an apply state, which does the divide-by-twenty multiply and the update.
// The digit pipeline adds one stage per digit and does not limit the rate.
// Reset clears all values and the sound phase and loads the configuration
// defaults. When rsp stalls, results wait in the digit stages and the queue
// keeps taking commands until it is full.

module rolling_decimal_counter_display_top
    import rdcd_pkg::*;
#(
    parameter int DIGITS = DIGITS_DEFAULT
)
(
    input  logic       clk,
    input  logic       rst_n,
    rdcd_cmd_if.sink   cmd,
    rdcd_rsp_if.source rsp,
    rdcd_cfg_if.sink   cfg
);

    logic     q_full;
    logic     push;
    q_entry_t push_entry;
    cfg_t     cfg_cur;
    logic     pop;
    logic     head_valid;
    q_entry_t head;
    logic     res_valid;
    logic     res_ready;
    result_t  res;
    result_t  out_res;

    // Command classification and configuration registers.
    rdcd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd.valid),
        .cmd_ready  (cmd.ready),
        .cmd_func   (cmd.func),
        .cmd_amount (cmd.amount),
        .cfg_valid  (cfg.valid),
        .cfg_ready  (cfg.ready),
        .cfg_index  (cfg.index),
        .cfg_data   (cfg.data),
        .q_full     (q_full),
        .push       (push),
        .push_entry (push_entry),
        .cfg        (cfg_cur)
    );

    // Queue between front and back end.
    rdcd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .full       (q_full),
        .head_valid (head_valid),
        .head       (head)
    );

    // Counter state and update logic.
    rdcd_exec u_exec (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_cur),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res)
    );

    // Decimal digit split and output register.
    rdcd_digits #(
        .DIGITS (DIGITS)
    ) u_digits (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (res_valid),
        .in_ready  (res_ready),
        .in_res    (res),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .out_res   (out_res),
        .out_bcd   (rsp.digits_bcd),
        .out_vis   (rsp.digit_visible)
    );

    assign rsp.display_updated = out_res.updated;
    assign rsp.play_sound      = out_res.sound;
    assign rsp.animating       = out_res.animating;
    assign rsp.shown_value     = out_res.value;

endmodule

FILE: design/rdcd_front.sv
// Front end: holds the configuration registers, accepts command transactions
// and classifies them into queue entries. Depends on rdcd_pkg.

module rdcd_front
    import rdcd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cmd_valid,
    output logic                  cmd_ready,
    input  logic [FUNC_W-1:0]     cmd_func,
    input  logic [VALUE_W-1:0]    cmd_amount,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  q_full,
    output logic                  push,
    output q_entry_t              push_entry,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Configuration writes are always taken.
    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_SNAP_THRESHOLD: cfg_next.snap_threshold = cfg_data[THRESH_W-1:0];
                CFG_SOUND_PERIOD:   cfg_next.sound_period   = cfg_data[PERIOD_W-1:0];
                CFG_ANIM_OFF:       cfg_next.anim_off       = cfg_data[0];
                default:            cfg_next                = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.snap_threshold <= SNAP_THRESHOLD_RST;
            cfg_reg.sound_period   <= SOUND_PERIOD_RST;
            cfg_reg.anim_off       <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // A command transaction is accepted whenever the queue has room.
    assign cmd_ready = !q_full;
    assign push      = cmd_valid && cmd_ready;

    // Decode the function code; unused codes become a no-op.
    always_comb
    begin
        push_entry.amount = cmd_amount;
        unique case (cmd_func)
            FUNC_TICK:   push_entry.op = OP_TICK;
            FUNC_ADD:    push_entry.op = OP_ADD;
            FUNC_SET:    push_entry.op = OP_SET;
            FUNC_FINISH: push_entry.op = OP_FINISH;
            FUNC_CLEAR:  push_entry.op = OP_CLEAR;
            default:     push_entry.op = OP_NOP;
        endcase
    end

endmodule

FILE: design/rdcd_queue.sv
// Short first-in first-out queue of classified operations between the front
// and the back end. Depends on rdcd_pkg.

module rdcd_queue
    import rdcd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  q_entry_t push_entry,
    input  logic     pop,
    output logic     full,
    output logic     head_valid,
    output q_entry_t head
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    q_entry_t           entries_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;

    assign full       = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = entries_reg[rd_ptr_reg];

    // Occupancy follows the push and pop strobes.
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Pointer and count registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

FILE: design/rdcd_exec.sv
// Back end: owns the target value, the shown value and the sound phase, and
// carries out one queued operation at a time. Depends on rdcd_pkg.

module rdcd_exec
    import rdcd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  cfg_t     cfg,
    input  logic     head_valid,
    input  q_entry_t head,
    output logic     pop,
    output logic     res_valid,
    input  logic     res_ready,
    output result_t  res
);

    // A tick is evaluated first and applied in the following cycle.
    typedef enum logic [1:0] {
        S_EVAL  = 2'b01,
        S_APPLY = 2'b10
    } state_t;

    state_t               state_reg;
    state_t               state_next;
    logic [VALUE_W-1:0]   target_reg;
    logic [VALUE_W-1:0]   target_next;
    logic [VALUE_W-1:0]   disp_reg;
    logic [VALUE_W-1:0]   disp_next;
    logic [PERIOD_W-1:0]  phase_reg;
    logic [PERIOD_W-1:0]  phase_next;

    // Tick evaluation results carried into the apply cycle.
    logic                 neq_reg;
    logic                 snap_reg;
    logic                 neg_reg;
    logic [VALUE_W-1:0]   mag_reg;

    logic [VALUE_W-1:0]   diff;
    logic [VALUE_W-1:0]   mag;
    logic                 snap;
    logic                 eval_tick;
    logic [2*VALUE_W-1:0] prod;
    logic [VALUE_W-1:0]   quot;
    logic [VALUE_W-1:0]   step;
    logic [PERIOD_W-1:0]  period;
    logic [PERIOD_W:0]    phase_inc;

    // Signed distance, its magnitude and the snap decision.
    assign diff      = target_reg - disp_reg;
    assign mag       = diff[VALUE_W-1] ? (~diff + 1'b1) : diff;
    assign snap      = cfg.anim_off || (mag < {{(VALUE_W-THRESH_W){1'b0}}, cfg.snap_threshold});
    assign eval_tick = (state_reg == S_EVAL) && head_valid && (head.op == OP_TICK);

    // Animated step: magnitude over twenty by reciprocal multiplication.
    assign prod = {{VALUE_W{1'b0}}, mag_reg} * {{VALUE_W{1'b0}}, RECIP_10};
    assign quot = VALUE_W'(prod >> SHIFT_DIV20);
    assign step = neg_reg ? (~quot + 1'b1) : quot;

    // Sound phase arithmetic; a period of zero acts as one.
    assign period    = (cfg.sound_period == '0) ? PERIOD_W'(1) : cfg.sound_period;
    assign phase_inc = {1'b0, phase_reg} + 1'b1;

    // A result is offered for every non-tick operation at once and for a tick
    // in its apply cycle.
    assign res_valid = ((state_reg == S_EVAL) && head_valid && (head.op != OP_TICK))
                       || (state_reg == S_APPLY);
    assign pop       = res_valid && res_ready;

    always_comb
    begin
        state_next    = state_reg;
        target_next   = target_reg;
        disp_next     = disp_reg;
        phase_next    = phase_reg;
        res.updated   = 1'b0;
        res.sound     = 1'b0;
        res.animating = (disp_reg != target_reg);
        unique case (state_reg)
            S_EVAL:
            begin
                if (eval_tick)
                begin
                    state_next = S_APPLY;
                end
                else
                begin
                    unique case (head.op)
                        OP_ADD:
                        begin
                            target_next   = target_reg + head.amount;
                            phase_next    = '0;
                            res.animating = (disp_reg != target_next);
                        end
                        OP_SET:
                        begin
                            target_next   = head.amount;
                            res.animating = (disp_reg != head.amount);
                        end
                        OP_FINISH:
                        begin
                            disp_next     = target_reg + 1'b1;
                            res.animating = 1'b1;
                        end
                        OP_CLEAR:
                        begin
                            target_next   = '0;
                            disp_next     = '0;
                            phase_next    = '0;
                            res.animating = 1'b0;
                        end
                        default:
                        begin
                            res.animating = (disp_reg != target_reg);
                        end
                    endcase
                end
            end
            S_APPLY:
            begin
                if (res_ready)
                begin
                    state_next = S_EVAL;
                end
                if (neq_reg && snap_reg)
                begin
                    disp_next     = target_reg;
                    res.updated   = 1'b1;
                    res.animating = 1'b0;
                end
                else if (neq_reg)
                begin
                    // The step is always smaller than the distance, so the
                    // counter keeps animating after a moving tick.
                    disp_next     = disp_reg + step;
                    phase_next    = (phase_inc >= {1'b0, period}) ? '0 : phase_inc[PERIOD_W-1:0];
                    res.sound     = (phase_reg == '0);
                    res.updated   = 1'b1;
                    res.animating = 1'b1;
                end
                else
                begin
                    res.animating = 1'b0;
                end
            end
            default:
            begin
                state_next = S_EVAL;
            end
        endcase
        res.value = disp_next;
    end

    // Target, shown value and sound phase change only when the result transaction is taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_EVAL;
            target_reg <= '0;
            disp_reg   <= '0;
            phase_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (pop)
            begin
                target_reg <= target_next;
                disp_reg   <= disp_next;
                phase_reg  <= phase_next;
            end
        end
    end

    // Tick evaluation registers.
    always_ff @(posedge clk)
    begin
        if (eval_tick)
        begin
            neq_reg  <= (diff != '0);
            snap_reg <= snap;
            neg_reg  <= diff[VALUE_W-1];
            mag_reg  <= mag;
        end
    end

endmodule

FILE: design/rdcd_digits.sv
// Digit pipeline: splits the shown value into decimal digits, one digit per
// stage, and holds the finished result for the output. Depends on rdcd_pkg.

module rdcd_digits
    import rdcd_pkg::*;
#(
    parameter int DIGITS = DIGITS_DEFAULT
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  result_t            in_res,
    output logic               out_valid,
    input  logic               out_ready,
    output result_t            out_res,
    output logic [BCD_W-1:0]   out_bcd,
    output logic [VIS_W-1:0]   out_vis
);

    localparam int STAGES = (DIGITS < MAX_SHOWN) ? DIGITS : MAX_SHOWN;

    dstage_t           stage_reg [0:STAGES];
    logic [STAGES:0]   valid_reg;
    logic [STAGES:0]   adv;
    dstage_t           calc [0:STAGES-1];

    // A stage may load when it is empty or its contents move on.
    always_comb
    begin
        adv[STAGES] = out_ready || !valid_reg[STAGES];
        for (int k = STAGES - 1; k >= 0; k--)
        begin
            adv[k] = !valid_reg[k] || adv[k+1];
        end
    end

    assign in_ready = adv[0];

    // Each stage peels off one digit by multiplying with the reciprocal of ten.
    always_comb
    begin
        logic [2*VALUE_W-1:0] prod;
        logic [VALUE_W-1:0]   quot;
        logic [VALUE_W-1:0]   quot10;
        logic [VALUE_W-1:0]   dig;
        for (int k = 0; k < STAGES; k++)
        begin
            prod   = {{VALUE_W{1'b0}}, stage_reg[k].rest} * {{VALUE_W{1'b0}}, RECIP_10};
            quot   = VALUE_W'(prod >> SHIFT_DIV10);
            quot10 = (quot << 3) + (quot << 1);
            dig    = stage_reg[k].rest - quot10;
            calc[k]             = stage_reg[k];
            calc[k].rest        = quot;
            calc[k].bcd[k*4 +: 4] = dig[3:0];
            calc[k].vis[k]      = (k == 0) || (stage_reg[k].rest != '0);
        end
    end

    // Stage valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                valid_reg[0] <= in_valid;
            end
            for (int k = 0; k < STAGES; k++)
            begin
                if (adv[k+1])
                begin
                    valid_reg[k+1] <= valid_reg[k];
                end
            end
        end
    end

    // Stage payloads.
    always_ff @(posedge clk)
    begin
        if (adv[0] && in_valid)
        begin
            stage_reg[0].res  <= in_res;
            stage_reg[0].rest <= in_res.value;
            stage_reg[0].bcd  <= '0;
            stage_reg[0].vis  <= '0;
        end
        for (int k = 0; k < STAGES; k++)
        begin
            if (adv[k+1] && valid_reg[k])
            begin
                stage_reg[k+1] <= calc[k];
            end
        end
    end

    assign out_valid = valid_reg[STAGES];
    assign out_res   = stage_reg[STAGES].res;
    assign out_bcd   = stage_reg[STAGES].bcd;
    assign out_vis   = stage_reg[STAGES].vis;

endmodule

FILE: design/rdcd_checker.sv
// Port-level checker for the rolling decimal counter display and the bind
// that attaches it to the top level. Depends on rdcd_pkg.

module rdcd_checker
    import rdcd_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               rsp_valid,
    input logic               rsp_ready,
    input logic               display_updated,
    input logic               play_sound,
    input logic               animating,
    input logic [VALUE_W-1:0] shown_value,
    input logic [BCD_W-1:0]   digits_bcd,
    input logic [VIS_W-1:0]   digit_visible
);

    // A stalled result transaction holds its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(shown_value))
        else $error("result changed while stalled");

    // A sound pulse only comes from a moving tick, which leaves the counter animating.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && play_sound |-> display_updated && animating)
        else $error("sound pulse without a moving refresh");

    // The lowest digit is always shown.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> digit_visible[0])
        else $error("lowest digit blanked");

    // A zero value shows a single zero digit.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (shown_value == '0) |-> (digit_visible == VIS_W'(1)) && (digits_bcd == '0))
        else $error("zero value shows extra digits");

endmodule

bind rolling_decimal_counter_display_top rdcd_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .display_updated (rsp.display_updated),
    .play_sound      (rsp.play_sound),
    .animating       (rsp.animating),
    .shown_value     (rsp.shown_value),
    .digits_bcd      (rsp.digits_bcd),
    .digit_visible   (rsp.digit_visible)
);
